// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the rect pair match block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while reset is released.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked at every rising clock edge, reset cycles included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/rpm_pkg.sv =====
// Shared types and constants for the rect pair match IoU block.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package rpm_pkg;

    // Default parameter values.
    localparam int DEF_MAX_PAIRS  = 1024;
    localparam int DEF_COORD_BITS = 12;

    // Fixed field widths of the tolerance and the result item.
    localparam int TOL_W  = 8;
    localparam int IOU_W  = 16;
    localparam int CNT_W  = 11;
    localparam int SUM_W  = 26;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd2;
    localparam logic [IOU_W-1:0] IOU_MAX   = 16'hFFFF;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = IOU_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_REF,
        S_MUL_CAND,
        S_MUL_OV,
        S_UNION,
        S_DIV_INIT,
        S_DIV,
        S_FINISH
    } t_state;

    // Operand pair routed to the shared multiplier.
    typedef enum logic [1:0] {
        MUL_REF,
        MUL_CAND,
        MUL_OV
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     union_en;
        logic     div_init;
        logic     div_step;
        logic     commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/rpm_ctrl.sv =====
// Sequencer of the rect pair match block: steps one item through the
// shared multiplier, the union adder and the divider. Uses rpm_pkg.
`default_nettype none

module rpm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire rpm_pkg::t_status i_status,
    output rpm_pkg::t_cmd        o_cmd
);
    import rpm_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_REF;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_REF;
                end
            end
            S_MUL_REF: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_REF;
                n_state       = S_MUL_CAND;
            end
            S_MUL_CAND: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CAND;
                n_state       = S_MUL_OV;
            end
            S_MUL_OV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_OV;
                n_state       = S_UNION;
            end
            S_UNION: begin
                o_cmd.union_en = 1'b1;
                n_state        = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hand the result over once the output register can take it.
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rpm_datapath.sv =====
// Datapath of the rect pair match block: edge compares, shared multiplier,
// union adder, restoring divider, run totals and output register. Uses rpm_pkg.
`default_nettype none

module rpm_datapath #(
    parameter int MAX_PAIRS  = rpm_pkg::DEF_MAX_PAIRS,
    parameter int COORD_BITS = rpm_pkg::DEF_COORD_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [rpm_pkg::TOL_W-1:0]   i_cfg_wr_data,
    input  wire logic [COORD_BITS-1:0]       i_ref_left,
    input  wire logic [COORD_BITS-1:0]       i_ref_top,
    input  wire logic [COORD_BITS-1:0]       i_ref_right,
    input  wire logic [COORD_BITS-1:0]       i_ref_bottom,
    input  wire logic [COORD_BITS-1:0]       i_cand_left,
    input  wire logic [COORD_BITS-1:0]       i_cand_top,
    input  wire logic [COORD_BITS-1:0]       i_cand_right,
    input  wire logic [COORD_BITS-1:0]       i_cand_bottom,
    input  wire logic                        i_last_pair,
    input  wire rpm_pkg::t_cmd               i_cmd,
    output rpm_pkg::t_status                 o_status,
    input  wire logic                        i_out_stall,
    output logic                             o_out_valid,
    output logic                             o_exact_match,
    output logic                             o_approx_match,
    output logic                             o_horiz_match,
    output logic                             o_vert_match,
    output logic [rpm_pkg::IOU_W-1:0]        o_iou,
    output logic [rpm_pkg::CNT_W-1:0]        o_exact_total,
    output logic [rpm_pkg::CNT_W-1:0]        o_approx_total,
    output logic [rpm_pkg::CNT_W-1:0]        o_horiz_total,
    output logic [rpm_pkg::CNT_W-1:0]        o_vert_total,
    output logic [rpm_pkg::SUM_W-1:0]        o_iou_total,
    output logic [rpm_pkg::CNT_W-1:0]        o_pair_total,
    output logic                             o_run_end
);
    import rpm_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;        // signed edge difference
    localparam int PW  = 2 * CB + 2;    // signed product
    localparam int OVW = 2 * CB;        // overlap area
    localparam int UNW = 2 * CB + 3;    // signed union, also divider remainder
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam longint unsigned SUM_CAP = longint'(MAX_PAIRS) * longint'(IOU_MAX);
    localparam int SW  = $clog2(SUM_CAP + 1);
    localparam logic [CW-1:0] CNT_CAP   = CW'(MAX_PAIRS);
    localparam logic [SW-1:0] SUM_CAP_W = SW'(SUM_CAP);

    function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a,
                                                input logic [CB-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [CB-1:0] overlap_len(input logic [CB-1:0] lo_a,
                                                   input logic [CB-1:0] lo_b,
                                                   input logic [CB-1:0] hi_a,
                                                   input logic [CB-1:0] hi_b);
        logic [CB-1:0] hi_min;
        logic [CB-1:0] lo_max;
        hi_min = (hi_a < hi_b) ? hi_a : hi_b;
        lo_max = (lo_a > lo_b) ? lo_a : lo_b;
        return (hi_min > lo_max) ? hi_min - lo_max : '0;
    endfunction

    function automatic logic [CW-1:0] count_up(input logic [CW-1:0] c, input logic hit);
        return (hit && (c < CNT_CAP)) ? c + 1'b1 : c;
    endfunction

    // Configuration and per-item registers.
    logic [TOL_W-1:0]        r_tol;
    logic                    r_exact, r_approx, r_horiz, r_vert, r_last;
    logic signed [DW-1:0]    r_rw, r_rh, r_cw, r_ch;
    logic [CB-1:0]           r_xo, r_yo;
    logic signed [PW-1:0]    r_ra, r_ca;
    logic [OVW-1:0]          r_ov;
    logic signed [UNW-1:0]   r_uni;
    logic [UNW-1:0]          r_rem;
    logic [IOU_W-1:0]        r_quo, r_fix;
    logic                    r_bypass;

    // Run totals.
    logic [CW-1:0]           r_exact_cnt, r_approx_cnt, r_horiz_cnt, r_vert_cnt, r_pair_cnt;
    logic [SW-1:0]           r_sum;
    logic                    r_out_valid;

    logic [CB-1:0]           d_l, d_t, d_r, d_b;
    logic [CB-1:0]           tol_ext;
    logic                    hit_h, hit_v;
    logic signed [DW-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [UNW-1:0]   ov_ext;
    logic                    uni_pos;
    logic [UNW-1:0]          rem_sh;
    logic [IOU_W-1:0]        iou_val;
    logic [CW-1:0]           n_exact_cnt, n_approx_cnt, n_horiz_cnt, n_vert_cnt, n_pair_cnt;
    logic [SW:0]             sum_wide;
    logic [SW-1:0]           n_sum;

    // Edge compares on the incoming item.
    always_comb begin
        d_l     = abs_diff(i_ref_left, i_cand_left);
        d_t     = abs_diff(i_ref_top, i_cand_top);
        d_r     = abs_diff(i_ref_right, i_cand_right);
        d_b     = abs_diff(i_ref_bottom, i_cand_bottom);
        tol_ext = CB'(r_tol);
        hit_h   = (d_l <= tol_ext) && (d_r <= tol_ext);
        hit_v   = (d_t <= tol_ext) && (d_b <= tol_ext);
    end

    // Shared multiplier operand select.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_REF: begin
                mul_a = r_rw;
                mul_b = r_rh;
            end
            MUL_CAND: begin
                mul_a = r_cw;
                mul_b = r_ch;
            end
            MUL_OV: begin
                mul_a = $signed({1'b0, r_xo});
                mul_b = $signed({1'b0, r_yo});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Divider checks and one restoring step.
    always_comb begin
        ov_ext  = $signed(UNW'(r_ov));
        uni_pos = !r_uni[UNW-1] && (r_uni != '0);
        rem_sh  = {r_rem[UNW-2:0], 1'b0};
        iou_val = r_bypass ? r_fix : r_quo;
    end

    // Totals including the current item.
    always_comb begin
        n_exact_cnt  = count_up(r_exact_cnt, r_exact);
        n_approx_cnt = count_up(r_approx_cnt, r_approx);
        n_horiz_cnt  = count_up(r_horiz_cnt, r_horiz);
        n_vert_cnt   = count_up(r_vert_cnt, r_vert);
        n_pair_cnt   = count_up(r_pair_cnt, 1'b1);
        sum_wide     = {1'b0, r_sum} + (SW + 1)'(iou_val);
        n_sum        = (sum_wide > {1'b0, SUM_CAP_W}) ? SUM_CAP_W : sum_wide[SW-1:0];
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // Item capture, products, union and division.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exact  <= (d_l == '0) && (d_t == '0) && (d_r == '0) && (d_b == '0);
            r_horiz  <= hit_h;
            r_vert   <= hit_v;
            r_approx <= hit_h && hit_v;
            r_last   <= i_last_pair;
            r_rw     <= $signed({1'b0, i_ref_right}) - $signed({1'b0, i_ref_left});
            r_rh     <= $signed({1'b0, i_ref_bottom}) - $signed({1'b0, i_ref_top});
            r_cw     <= $signed({1'b0, i_cand_right}) - $signed({1'b0, i_cand_left});
            r_ch     <= $signed({1'b0, i_cand_bottom}) - $signed({1'b0, i_cand_top});
            r_xo     <= overlap_len(i_ref_left, i_cand_left, i_ref_right, i_cand_right);
            r_yo     <= overlap_len(i_ref_top, i_cand_top, i_ref_bottom, i_cand_bottom);
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_REF:  r_ra <= mul_p;
                MUL_CAND: r_ca <= mul_p;
                MUL_OV:   r_ov <= mul_p[OVW-1:0];
                default:  r_ov <= r_ov;
            endcase
        end
        if (i_cmd.union_en) begin
            r_uni <= UNW'(r_ra) + UNW'(r_ca) - ov_ext;
        end
        if (i_cmd.div_init) begin
            // Empty or malformed union gives zero; overlap not below union saturates.
            r_bypass <= !uni_pos || (ov_ext >= r_uni);
            r_fix    <= uni_pos ? IOU_MAX : '0;
            r_rem    <= UNW'(r_ov);
            r_quo    <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem_sh >= $unsigned(r_uni)) begin
                r_rem <= rem_sh - $unsigned(r_uni);
                r_quo <= {r_quo[IOU_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[IOU_W-2:0], 1'b0};
            end
        end
    end

    // Run totals: saturate at the bound, clear after the last item of a run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_cnt  <= '0;
            r_approx_cnt <= '0;
            r_horiz_cnt  <= '0;
            r_vert_cnt   <= '0;
            r_pair_cnt   <= '0;
            r_sum        <= '0;
        end else if (i_cmd.commit) begin
            r_exact_cnt  <= r_last ? '0 : n_exact_cnt;
            r_approx_cnt <= r_last ? '0 : n_approx_cnt;
            r_horiz_cnt  <= r_last ? '0 : n_horiz_cnt;
            r_vert_cnt   <= r_last ? '0 : n_vert_cnt;
            r_pair_cnt   <= r_last ? '0 : n_pair_cnt;
            r_sum        <= r_last ? '0 : n_sum;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_exact_match  <= r_exact;
            o_approx_match <= r_approx;
            o_horiz_match  <= r_horiz;
            o_vert_match   <= r_vert;
            o_iou          <= iou_val;
            o_exact_total  <= CNT_W'(n_exact_cnt);
            o_approx_total <= CNT_W'(n_approx_cnt);
            o_horiz_total  <= CNT_W'(n_horiz_cnt);
            o_vert_total   <= CNT_W'(n_vert_cnt);
            o_pair_total   <= CNT_W'(n_pair_cnt);
            o_iou_total    <= SUM_W'(n_sum);
            o_run_end      <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/rect_pair_match_iou.sv =====
// Each accepted item makes three passes through the one shared multiplier,
// then the union adder, then the 16-step restoring divider for the IoU quotient,
// and enters the output register once it is free; only then is a new item taken.
// Reset is synchronous, active low: it idles the sequencer, empties the output
// register, zeroes all run totals and sets the edge tolerance to 2.
`default_nettype none

module rect_pair_match_iou #(
    parameter int MAX_PAIRS  = rpm_pkg::DEF_MAX_PAIRS,
    parameter int COORD_BITS = rpm_pkg::DEF_COORD_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [rpm_pkg::TOL_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [COORD_BITS-1:0]     i_ref_left,
    input  wire logic [COORD_BITS-1:0]     i_ref_top,
    input  wire logic [COORD_BITS-1:0]     i_ref_right,
    input  wire logic [COORD_BITS-1:0]     i_ref_bottom,
    input  wire logic [COORD_BITS-1:0]     i_cand_left,
    input  wire logic [COORD_BITS-1:0]     i_cand_top,
    input  wire logic [COORD_BITS-1:0]     i_cand_right,
    input  wire logic [COORD_BITS-1:0]     i_cand_bottom,
    input  wire logic                      i_last_pair,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_exact_match,
    output logic                           o_approx_match,
    output logic                           o_horiz_match,
    output logic                           o_vert_match,
    output logic [rpm_pkg::IOU_W-1:0]      o_iou,
    output logic [rpm_pkg::CNT_W-1:0]      o_exact_total,
    output logic [rpm_pkg::CNT_W-1:0]      o_approx_total,
    output logic [rpm_pkg::CNT_W-1:0]      o_horiz_total,
    output logic [rpm_pkg::CNT_W-1:0]      o_vert_total,
    output logic [rpm_pkg::SUM_W-1:0]      o_iou_total,
    output logic [rpm_pkg::CNT_W-1:0]      o_pair_total,
    output logic                           o_run_end
);
    import rpm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    rpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic, totals and output register.
    rpm_datapath #(
        .MAX_PAIRS  (MAX_PAIRS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_ref_left     (i_ref_left),
        .i_ref_top      (i_ref_top),
        .i_ref_right    (i_ref_right),
        .i_ref_bottom   (i_ref_bottom),
        .i_cand_left    (i_cand_left),
        .i_cand_top     (i_cand_top),
        .i_cand_right   (i_cand_right),
        .i_cand_bottom  (i_cand_bottom),
        .i_last_pair    (i_last_pair),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_exact_match  (o_exact_match),
        .o_approx_match (o_approx_match),
        .o_horiz_match  (o_horiz_match),
        .o_vert_match   (o_vert_match),
        .o_iou          (o_iou),
        .o_exact_total  (o_exact_total),
        .o_approx_total (o_approx_total),
        .o_horiz_total  (o_horiz_total),
        .o_vert_total   (o_vert_total),
        .o_iou_total    (o_iou_total),
        .o_pair_total   (o_pair_total),
        .o_run_end      (o_run_end)
    );

endmodule

`default_nettype wire

// ===== rtl/rpm_checker.sv =====
// Port-level checker for the rect pair match block, bound to its top level.
// Depends on rpm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpm_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic                      o_exact_match,
    input wire logic                      o_approx_match,
    input wire logic                      o_horiz_match,
    input wire logic                      o_vert_match,
    input wire logic [rpm_pkg::IOU_W-1:0] o_iou
);
    import rpm_pkg::*;

    // Reset empties the output register.
    `ASSERT_CLK(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)

    // A waiting result holds until it is taken.
    `ASSERT_CLK_RST(a_out_holds, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_iou))

    // An accepted item keeps the input side busy while it is worked on.
    `ASSERT_CLK_RST(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)

    // The match flags of one result agree with each other.
    `ASSERT_CLK_RST(a_flags_agree, i_clk, i_rst_n, o_out_valid |-> (o_approx_match == (o_horiz_match && o_vert_match)) && (!o_exact_match || o_approx_match))

endmodule

bind rect_pair_match_iou rpm_checker u_rpm_checker (.*);

`default_nettype wire
